### rtl/dptd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dptd_pkg;

  // One input word: a byte of posting block text and its block-start flag.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       block_start;
  } in_word_t;

  // One result word: absolute page id, record index and the clamp flag.
  typedef struct packed {
    logic [31:0] page_id;
    logic [15:0] record_index;
    logic        gap_saturated;
  } out_word_t;

  // Classification of one text byte against the current delimiter and radix.
  typedef struct packed {
    logic       is_delim;
    logic       digit_ok;
    logic [5:0] digit;
  } char_class_t;

  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS  = 8;
  localparam int unsigned BASE_BITS      = 6;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DELIMITER  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VALUE_BASE = 1'd1;

  localparam logic [7:0]           DELIMITER_RESET = 8'd44;
  localparam logic [BASE_BITS-1:0] BASE_RESET      = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_MIN        = 6'd2;
  localparam logic [BASE_BITS-1:0] BASE_MAX        = 6'd36;
  localparam logic [BASE_BITS-1:0] DIGIT_NONE      = 6'd36;

endpackage

`default_nettype wire

### rtl/delta_posting_text_decoder_core.sv
// Channel   Direction  Word          Handshake
// in_       input      in_word_t     in_valid / in_stall
// out_      output     out_word_t    out_valid / out_stall
// cfg_      input      register      cfg_we, one write per cycle
//
// Each word passes the input register and each delimiter's result the result
// register: one word per cycle sustained while results are not stalled, with
// the gap state updated in the cycle that the word leaves the input register.
// Reset (rst_n low, synchronous) clears the running state and both valid
// flags, and restores the delimiter and radix registers to their defaults.
// A stalled result holds back delimiter words, and every byte queued behind one.
`timescale 1ns / 1ps
`default_nettype none

module delta_posting_text_decoder_core #(
  parameter int unsigned PAGE_BITS  = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,

  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire dptd_pkg::in_word_t                  in_data,

  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output dptd_pkg::out_word_t                      out_data,

  input  wire logic                                cfg_we,
  input  wire logic [dptd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [dptd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // Configuration registers.
  logic [7:0]                     delim_r;
  logic [dptd_pkg::BASE_BITS-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= dptd_pkg::DELIMITER_RESET;
      base_r  <= dptd_pkg::BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dptd_pkg::CFG_DELIMITER:  delim_r <= cfg_data;
        dptd_pkg::CFG_VALUE_BASE: base_r  <= cfg_data[dptd_pkg::BASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic               s1_valid_r, s1_valid_nxt;
  dptd_pkg::in_word_t s1_word_r;
  logic               s1_move;
  logic               in_take;

  // Result register stage.
  logic                out_valid_r, out_valid_nxt;
  dptd_pkg::out_word_t out_word_r;
  logic                out_free;

  dptd_pkg::char_class_t cls;
  logic                  emit;
  dptd_pkg::out_word_t   result;

  dptd_char_class u_class (
    .text_byte  (s1_word_r.text_byte),
    .delimiter  (delim_r),
    .value_base (base_r),
    .cls        (cls)
  );

  dptd_gap_acc #(
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s1_move),
    .block_start (s1_word_r.block_start),
    .cls         (cls),
    .value_base  (base_r),
    .emit        (emit),
    .result      (result)
  );

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // A word leaves the input register unless it has a result with nowhere to go.
  assign s1_move  = s1_valid_r && (!emit || out_free);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_data;
    end
    if (s1_move && emit) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

`ifndef NO_ASSERTIONS
  // A delimiter that leaves the input register always lands a result.
  a_delim_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && cls.is_delim |=> out_valid_r)
    else $error("delimiter word produced no result");

  // Back-pressure toward the input only comes from a word held in stage one.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && emit && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  // A taken result with nothing new behind it empties the result register.
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !(s1_move && emit) |=> !out_valid_r)
    else $error("result word repeated");
`endif

endmodule

`default_nettype wire

### rtl/dptd_char_class.sv
`timescale 1ns / 1ps
`default_nettype none

module dptd_char_class (
  input  wire logic [7:0]                    text_byte,
  input  wire logic [7:0]                    delimiter,
  input  wire logic [dptd_pkg::BASE_BITS-1:0] value_base,
  output dptd_pkg::char_class_t              cls
);

  logic [dptd_pkg::BASE_BITS-1:0] digit;
  logic                           base_ok;

  // Digits are 0-9, then a-z or A-Z for 10-35; anything else is no digit.
  always_comb begin
    if (text_byte inside {[8'h30:8'h39]}) begin
      digit = 6'(text_byte - 8'h30);
    end else if (text_byte inside {[8'h61:8'h7a]}) begin
      digit = 6'(text_byte - 8'h61 + 8'd10);
    end else if (text_byte inside {[8'h41:8'h5a]}) begin
      digit = 6'(text_byte - 8'h41 + 8'd10);
    end else begin
      digit = dptd_pkg::DIGIT_NONE;
    end
  end

  assign base_ok = (value_base >= dptd_pkg::BASE_MIN) && (value_base <= dptd_pkg::BASE_MAX);

  assign cls.is_delim = (text_byte == delimiter);
  assign cls.digit_ok = base_ok && (digit < value_base);
  assign cls.digit    = digit;

endmodule

`default_nettype wire

### rtl/dptd_gap_acc.sv
`timescale 1ns / 1ps
`default_nettype none

module dptd_gap_acc #(
  parameter int unsigned PAGE_BITS  = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           advance,
  input  wire logic                           block_start,
  input  wire dptd_pkg::char_class_t          cls,
  input  wire logic [dptd_pkg::BASE_BITS-1:0] value_base,
  output logic                                emit,
  output dptd_pkg::out_word_t                 result
);

  localparam int unsigned PROD_BITS = PAGE_BITS + dptd_pkg::BASE_BITS + 1;

  logic [PAGE_BITS-1:0]  running_r, running_nxt;
  logic [PAGE_BITS-1:0]  acc_r, acc_nxt;
  logic                  stopped_r, stopped_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  logic [PAGE_BITS-1:0]  run_eff, acc_eff, page_sum;
  logic                  stopped_eff, ovf_eff;
  logic [COUNT_BITS-1:0] count_eff;
  logic [PROD_BITS-1:0]  prod;
  logic                  prod_ovf;
  logic [63:0]           page_ext;
  logic [31:0]           count_ext;

  // A block start clears the running state before the byte is applied.
  assign run_eff     = block_start ? '0 : running_r;
  assign acc_eff     = block_start ? '0 : acc_r;
  assign stopped_eff = block_start ? 1'b0 : stopped_r;
  assign ovf_eff     = block_start ? 1'b0 : ovf_r;
  assign count_eff   = block_start ? '0 : count_r;

  // acc * base + digit exceeds the page range exactly when the model's
  // division-based overflow test fires.
  assign prod     = PROD_BITS'(acc_eff) * PROD_BITS'(value_base) + PROD_BITS'(cls.digit);
  assign prod_ovf = |prod[PROD_BITS-1:PAGE_BITS];
  assign page_sum = run_eff + acc_eff;

  always_comb begin
    running_nxt = run_eff;
    acc_nxt     = acc_eff;
    stopped_nxt = stopped_eff;
    ovf_nxt     = ovf_eff;
    count_nxt   = count_eff;
    if (cls.is_delim) begin
      running_nxt = page_sum;
      acc_nxt     = '0;
      stopped_nxt = 1'b0;
      ovf_nxt     = 1'b0;
      if (!(&count_eff)) begin
        count_nxt = count_eff + 1'b1;
      end
    end else if (!stopped_eff) begin
      if (cls.digit_ok) begin
        if (prod_ovf) begin
          acc_nxt = '1;
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = prod[PAGE_BITS-1:0];
        end
      end else begin
        stopped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      acc_r     <= '0;
      stopped_r <= 1'b0;
      ovf_r     <= 1'b0;
      count_r   <= '0;
    end else if (advance) begin
      running_r <= running_nxt;
      acc_r     <= acc_nxt;
      stopped_r <= stopped_nxt;
      ovf_r     <= ovf_nxt;
      count_r   <= count_nxt;
    end
  end

  assign page_ext  = 64'(page_sum);
  assign count_ext = 32'(count_eff);

  assign emit                 = cls.is_delim;
  assign result.page_id       = page_ext[31:0];
  assign result.record_index  = count_ext[15:0];
  assign result.gap_saturated = ovf_eff;

endmodule

`default_nettype wire

### bench/delta_posting_text_decoder_core_test.sv
`timescale 1ns / 1ps

module delta_posting_text_decoder_core_test;

  // With no word accepted on either side for this many cycles, the run is
  // declared hung. The longest legal quiet stretch is the receiver hold below.
  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES = 400;
  // Bytes pass through the input register; this margin covers bytes that
  // produce no result and may still sit in the pipeline.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [31:0] PAGE_TOP  = 32'hFFFF_FFFF;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;
  localparam int unsigned PHASE_WORDS = 100;
  localparam int unsigned NUM_PHASES  = 8;

  logic                                clk       = 1'b0;
  logic                                rst_n     = 1'b0;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  dptd_pkg::in_word_t                  in_data   = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  dptd_pkg::out_word_t                 out_data;
  logic                                cfg_we    = 1'b0;
  logic [dptd_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [dptd_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

  // Shadow of the decoder: the format registers and the running block state.
  logic [7:0]                     fmt_delim;
  logic [dptd_pkg::BASE_BITS-1:0] fmt_base;
  logic [31:0]                    run_page;
  logic [31:0]                    gap_acc;
  bit                             gap_frozen;
  bit                             gap_clamped;
  logic [15:0]                    rec_count;

  // Page ids still owed by the block, oldest first.
  dptd_pkg::out_word_t expected_pages[$];

  int error_count = 0;
  int idle_cycles = 0;
  // no_idle removes the random gaps on both sides; hold_req asks the
  // receiver for one long stall to fill the block up.
  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  delta_posting_text_decoder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Digit value of a text byte, with DIGIT_NONE for anything that is not
  // a digit or letter.
  function automatic logic [dptd_pkg::BASE_BITS-1:0] digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return dptd_pkg::BASE_BITS'(c - "0");
    if (c >= "a" && c <= "z") return dptd_pkg::BASE_BITS'(c - "a" + 10);
    if (c >= "A" && c <= "Z") return dptd_pkg::BASE_BITS'(c - "A" + 10);
    return dptd_pkg::DIGIT_NONE;
  endfunction

  function automatic void clear_block();
    run_page    = '0;
    gap_acc     = '0;
    gap_frozen  = 1'b0;
    gap_clamped = 1'b0;
    rec_count   = '0;
  endfunction

  // Advances the shadow state by one accepted word and queues the page id
  // that a delimiter produces.
  function automatic void decode_byte(dptd_pkg::in_word_t w);
    dptd_pkg::out_word_t            r;
    logic [dptd_pkg::BASE_BITS-1:0] d;
    longint unsigned                headroom;
    if (w.block_start) clear_block();
    if (w.text_byte == fmt_delim) begin
      // The delimiter wins even when it is also a valid digit.
      run_page        = run_page + gap_acc;
      r.page_id       = run_page;
      r.record_index  = rec_count;
      r.gap_saturated = gap_clamped;
      expected_pages  = {expected_pages, r};
      if (rec_count != COUNT_TOP) rec_count = rec_count + 16'd1;
      gap_acc     = '0;
      gap_frozen  = 1'b0;
      gap_clamped = 1'b0;
    end else if (!gap_frozen) begin
      d = digit_value(w.text_byte);
      if (fmt_base >= dptd_pkg::BASE_MIN && fmt_base <= dptd_pkg::BASE_MAX &&
          d < fmt_base) begin
        headroom = (64'(PAGE_TOP) - 64'(d)) / 64'(fmt_base);
        if (64'(gap_acc) > headroom) begin
          gap_acc     = PAGE_TOP;
          gap_clamped = 1'b1;
        end else begin
          gap_acc = gap_acc * 32'(fmt_base) + 32'(d);
        end
      end else begin
        // Any byte that is no digit of the radix, including signs and whitespace, freezes the gap.
        gap_frozen = 1'b1;
      end
    end
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Result checker: every accepted result word is matched against the
  // oldest expectation, field by field.
  always @(posedge clk) begin
    dptd_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pages.size() == 0) begin
        report_error($sformatf("unexpected result page_id=%0d record_index=%0d",
                               out_data.page_id, out_data.record_index));
      end else begin
        want = expected_pages.pop_front();
        if (out_data.page_id !== want.page_id)
          report_error($sformatf("page_id %0d, expected %0d",
                                 out_data.page_id, want.page_id));
        if (out_data.record_index !== want.record_index)
          report_error($sformatf("record_index %0d, expected %0d",
                                 out_data.record_index, want.record_index));
        if (out_data.gap_saturated !== want.gap_saturated)
          report_error($sformatf("gap_saturated %0b, expected %0b",
                                 out_data.gap_saturated, want.gap_saturated));
      end
    end
  end

  // Watchdog on progress: any accepted word on either channel resets it.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: before each result it stalls for a random number of cycles,
  // or once for a long hold when the backpressure test asks for it. The
  // stall is only ever raised or lowered once per edge.
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 15);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Sends one word after a random gap and waits until the block takes it.
  // Valid is left high after acceptance so back-to-back words never see a
  // low and a high assignment in the same step.
  task automatic send_byte(input logic [7:0] c, input bit start);
    int                 gap;
    dptd_pkg::in_word_t w;
    w.text_byte   = c;
    w.block_start = start;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(w);
  endtask

  // Sends a string of text; the first byte optionally opens a new block.
  task automatic send_text(input string s, input bit start);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], start && (i == 0));
  endtask

  // Waits until every expected result is out and the pipeline has emptied
  // of bytes that produce nothing, so the format may be changed safely.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_pages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dptd_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [dptd_pkg::CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dptd_pkg::CFG_DELIMITER) fmt_delim = val;
    else fmt_base = val[dptd_pkg::BASE_BITS-1:0];
    @(posedge clk);
  endtask

  // The base word may carry junk in its upper bits; only six bits count.
  task automatic set_format(input logic [7:0] delim, input logic [7:0] base_word);
    drain_pipe();
    write_reg(dptd_pkg::CFG_DELIMITER, delim);
    write_reg(dptd_pkg::CFG_VALUE_BASE, base_word);
  endtask

  // Reset format: decimal gaps with a comma. A letter and a sign each stop
  // the number, and an empty gap still yields a record.
  task automatic test_reset_format();
    send_text("9z1,-3,,", 1'b1);
  endtask

  // Base 36 overflow clamps the gap, and the next gap wraps the page sum.
  task automatic test_gap_saturation();
    set_format(dptd_pkg::DELIMITER_RESET, 8'd36);
    send_text("zZzzzzz,1,", 1'b1);
  endtask

  // A delimiter that is also a digit ends the gap instead of adding to it.
  task automatic test_digit_delimiter();
    set_format("5", 8'd10);
    send_text("1515", 1'b1);
  endtask

  // Extreme byte values as delimiter and as text, in the smallest radix.
  task automatic test_byte_extremes();
    set_format(8'hFF, 8'd2);
    send_byte("1", 1'b1);
    send_byte("0", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("1", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Radix values outside 2..36 accept no digit, so every gap is zero.
  task automatic test_invalid_base();
    logic [7:0] bad [4] = '{8'd0, 8'd1, 8'd37, 8'd63};
    for (int i = 0; i < 4; i++) begin
      set_format(dptd_pkg::DELIMITER_RESET, bad[i]);
      send_text("1,", 1'b1);
    end
  endtask

  // The receiver holds off while the sender keeps offering delimiters and
  // digits back to back, so the block fills and stalls its input.
  task automatic test_backpressure();
    drain_pipe();
    hold_req = 1'b1;
    no_idle  = 1'b1;
    for (int i = 0; i < 60; i++) send_byte((i % 3 == 0) ? "7" : fmt_delim, i == 0);
    no_idle = 1'b0;
  endtask

  // Random text in several formats: mostly well-formed gap numbers with
  // random digits and letter case, mixed with noise bytes, broken numbers,
  // long numbers that clamp, and random block starts.
  task automatic test_random_text();
    logic [7:0] delim;
    int         radix;
    int         kind;
    int         len;
    int         digit;
    int         sent;
    bit         start;
    logic [7:0] c;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin delim = 8'd44; radix = 10; end
        1: begin delim = 8'h00; radix = 2; end
        2: begin delim = 8'hFF; radix = 36; end
        3: begin delim = "7";   radix = 16; end
        default: begin
          delim = 8'($urandom_range(0, 255));
          radix = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(2, 36);
        end
      endcase
      set_format(delim, 8'(radix) | (8'($urandom_range(0, 3)) << 6));
      // Every fourth phase runs with both sides at full rate.
      no_idle = (phase % 4 == 3);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        kind  = $urandom_range(0, 9);
        start = ($urandom_range(0, 9) == 0);
        if (kind == 0) begin
          send_byte(8'($urandom_range(0, 255)), start);
          sent++;
        end else begin
          len = (kind == 9) ? $urandom_range(8, 40) : $urandom_range(0, 4);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 31) == 0) begin
              c = 8'($urandom_range(0, 255));
            end else begin
              digit = $urandom_range(0, ((radix >= 2 && radix <= 36) ? radix : 36) - 1);
              if (digit < 10) c = 8'("0" + digit);
              else if ($urandom_range(0, 1)) c = 8'("a" + digit - 10);
              else c = 8'("A" + digit - 10);
            end
            send_byte(c, start && (i == 0));
            sent++;
          end
          send_byte(delim, start && (len == 0));
          sent++;
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    fmt_delim = dptd_pkg::DELIMITER_RESET;
    fmt_base  = dptd_pkg::BASE_RESET;
    clear_block();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_format();
    test_gap_saturation();
    test_digit_delimiter();
    test_byte_extremes();
    test_invalid_base();
    test_backpressure();
    test_random_text();

    drain_pipe();
    if (error_count == 0 && expected_pages.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
